[sv/sha256_block_hash_defines.svh]
// ----------------------------------------------------------------------------
// SHA-256 block hash assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef SHA256_BLOCK_HASH_DEFINES_SVH
`define SHA256_BLOCK_HASH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SHA256_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha256 check failed");

// next-cycle implication, disabled during reset
`define SHA256_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha256 check failed");

`endif

[sv/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Constants, types and round functions shared by the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int WordW    = 32;
   localparam int Rounds   = 64;
   localparam int BlockW   = 16;
   localparam int DigestW  = 8;

   localparam logic [31:0] RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] InitHash [DigestW] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef logic [WordW-1:0] word_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load_word;
      logic       start_rounds;
      logic       do_round;
      logic [5:0] round_idx;
      logic       fold;
      logic       restore_iv;
      logic [2:0] emit_idx;
   } cmd_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordW - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

[sv/sha256_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sha256_req_if;
   logic                 valid;
   logic                 ready;
   sha256_pkg::word_type message_word;
   logic                 final_block;

   modport source (output valid, output message_word, output final_block, input ready);
   modport sink   (input valid, input message_word, input final_block, output ready);
endinterface

interface sha256_rsp_if;
   logic                 valid;
   logic                 ready;
   sha256_pkg::word_type digest_word;
   logic [2:0]           word_position;
   logic                 last_word;

   modport source (output valid, output digest_word, output word_position,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_position,
                   input last_word, output ready);
endinterface

[sv/sha256_block_hash.sv]
// ----------------------------------------------------------------------------
// SHA-256 block hash
// Takes padded message words sixteen to a block, compresses each block into
// the chaining state and returns the eight digest words after a final block.
// A block takes 16 word transfers, then 64 rounds (one round a cycle in the
// single round unit) and a fold into the chaining state in the fold state.
// No words are taken during the rounds. After a final block the eight digest
// words follow, one transfer each, and the next message starts from the
// initial hash values.
// ----------------------------------------------------------------------------
module sha256_block_hash (
   input logic         clock,
   input logic         reset,
   sha256_req_if.sink  req_bus,
   sha256_rsp_if.source rsp_bus
);

   sha256_pkg::cmd_type cmd;

   sha256_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_final (req_bus.final_block),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   sha256_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .message_word  (req_bus.message_word),
      .digest_word   (rsp_bus.digest_word),
      .word_position (rsp_bus.word_position),
      .last_word     (rsp_bus.last_word)
   );

endmodule

[sv/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word collection, 64 rounds, chaining fold and digest output.
// ----------------------------------------------------------------------------
`include "sha256_block_hash_defines.svh"

module sha256_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_final,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha256_pkg::cmd_type cmd
);

   sha256_pkg::state_type state_ff, state_in;
   logic [3:0] word_cnt_ff, word_cnt_in;
   logic [5:0] round_cnt_ff, round_cnt_in;
   logic [2:0] emit_cnt_ff, emit_cnt_in;
   logic       final_ff, final_in;
   logic       req_xfer, rsp_xfer;

   assign req_ready = (state_ff == sha256_pkg::ST_COLLECT);
   assign rsp_valid = (state_ff == sha256_pkg::ST_EMIT);
   assign req_xfer  = req_valid & req_ready;
   assign rsp_xfer  = rsp_valid & rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha256_pkg::ST_COLLECT: begin
            if (req_xfer && word_cnt_ff == 4'd15) state_in = sha256_pkg::ST_ROUND;
         end
         sha256_pkg::ST_ROUND: begin
            if (round_cnt_ff == 6'd63) state_in = sha256_pkg::ST_FOLD;
         end
         sha256_pkg::ST_FOLD: begin
            state_in = final_ff ? sha256_pkg::ST_EMIT : sha256_pkg::ST_COLLECT;
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_xfer && emit_cnt_ff == 3'd7) state_in = sha256_pkg::ST_COLLECT;
         end
         default: state_in = sha256_pkg::ST_COLLECT;
      endcase
   end

   always_comb begin
      word_cnt_in  = word_cnt_ff;
      round_cnt_in = round_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      final_in     = final_ff;
      cmd          = '0;
      cmd.round_idx = round_cnt_ff;
      cmd.emit_idx  = emit_cnt_ff;
      case (state_ff)
         sha256_pkg::ST_COLLECT: begin
            if (req_xfer) begin
               cmd.load_word = 1'b1;
               word_cnt_in   = word_cnt_ff + 4'd1;
               if (word_cnt_ff == 4'd15) begin
                  cmd.start_rounds = 1'b1;
                  final_in         = req_final;
                  round_cnt_in     = '0;
               end
            end
         end
         sha256_pkg::ST_ROUND: begin
            cmd.do_round = 1'b1;
            round_cnt_in = round_cnt_ff + 6'd1;
         end
         sha256_pkg::ST_FOLD: begin
            cmd.fold    = 1'b1;
            emit_cnt_in = '0;
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_xfer) begin
               emit_cnt_in = emit_cnt_ff + 3'd1;
               if (emit_cnt_ff == 3'd7) cmd.restore_iv = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha256_pkg::ST_COLLECT;
         word_cnt_ff  <= '0;
         round_cnt_ff <= '0;
         emit_cnt_ff  <= '0;
         final_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_cnt_ff  <= word_cnt_in;
         round_cnt_ff <= round_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         final_ff     <= final_in;
      end
   end

   `SHA256_ASSERT_NEXT(a_block_starts_rounds, clock, reset,
      req_xfer && word_cnt_ff == 4'd15,
      state_ff == sha256_pkg::ST_ROUND && round_cnt_ff == 6'd0 && word_cnt_ff == 4'd0)
   `SHA256_ASSERT_NEXT(a_last_round_folds, clock, reset,
      state_ff == sha256_pkg::ST_ROUND && round_cnt_ff == 6'd63,
      state_ff == sha256_pkg::ST_FOLD)
   `SHA256_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `SHA256_ASSERT_NEXT(a_emit_done, clock, reset,
      rsp_xfer && emit_cnt_ff == 3'd7,
      state_ff == sha256_pkg::ST_COLLECT && word_cnt_ff == 4'd0)

endmodule

[sv/sha256_dp.sv]
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Schedule window, working variables, round unit and chaining state.
// ----------------------------------------------------------------------------
module sha256_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  sha256_pkg::cmd_type  cmd,
   input  sha256_pkg::word_type message_word,
   output sha256_pkg::word_type digest_word,
   output logic [2:0]           word_position,
   output logic                 last_word
);

   sha256_pkg::word_type sched_ff [sha256_pkg::BlockW];
   sha256_pkg::word_type work_ff  [sha256_pkg::DigestW];
   sha256_pkg::word_type chain_ff [sha256_pkg::DigestW];
   sha256_pkg::word_type expand, t1, t2;

   always_comb begin
      expand = sched_ff[0] + sha256_pkg::small_sigma0(sched_ff[1]) + sched_ff[9]
             + sha256_pkg::small_sigma1(sched_ff[14]);
      t1 = work_ff[7] + sha256_pkg::big_sigma1(work_ff[4])
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + sha256_pkg::RoundK[cmd.round_idx] + sched_ff[0];
      t2 = sha256_pkg::big_sigma0(work_ff[0])
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
            ^ (work_ff[1] & work_ff[2]));
   end

   // schedule window: entry 0 is the word for the current round
   always_ff @(posedge clock) begin
      if (cmd.load_word || cmd.do_round) begin
         for (int i = 0; i < sha256_pkg::BlockW - 1; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[sha256_pkg::BlockW-1] <= cmd.load_word ? message_word : expand;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_rounds) begin
         for (int i = 0; i < sha256_pkg::DigestW; i++) work_ff[i] <= chain_ff[i];
      end else if (cmd.do_round) begin
         work_ff[0] <= t1 + t2;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= work_ff[1];
         work_ff[3] <= work_ff[2];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[5] <= work_ff[4];
         work_ff[6] <= work_ff[5];
         work_ff[7] <= work_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restore_iv) begin
         for (int i = 0; i < sha256_pkg::DigestW; i++) chain_ff[i] <= sha256_pkg::InitHash[i];
      end else if (cmd.fold) begin
         for (int i = 0; i < sha256_pkg::DigestW; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
      end
   end

   assign digest_word   = chain_ff[cmd.emit_idx];
   assign word_position = cmd.emit_idx;
   assign last_word     = (cmd.emit_idx == 3'd7);

endmodule

[tb/sha256_digest_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 digest check
// Watches word transfers into the hash block, keeps its own copy of the
// chaining state and block buffer, and predicts the eight digest words of
// every final block. Each digest transfer is compared field by field with
// the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_check (
   input  logic  clock,
   input  logic  reset,
   sha256_req_if req_bus,
   sha256_rsp_if rsp_bus,
   output int    fail_count,
   output int    expected_left,
   output int    digest_count
);

   typedef struct packed {
      sha256_pkg::word_type digest;
      logic [2:0]           position;
      logic                 last;
   } digest_entry_type;

   sha256_pkg::word_type chain_state [8];
   sha256_pkg::word_type block_buf [16];
   logic [3:0]           fill_count;
   digest_entry_type     digest_queue [$];

   function automatic sha256_pkg::word_type ror32(input sha256_pkg::word_type x,
                                                  input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void fold_block_into_chain();
      sha256_pkg::word_type sched [64];
      sha256_pkg::word_type v [8];
      sha256_pkg::word_type t1;
      sha256_pkg::word_type t2;
      sha256_pkg::word_type s0;
      sha256_pkg::word_type s1;
      for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      v = chain_state;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[i] + sched[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_state[i] = chain_state[i] + v[i];
   endfunction

   task automatic report_mismatch(input string what, input sha256_pkg::word_type want,
                                  input sha256_pkg::word_type got);
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      digest_entry_type head;
      if (reset) begin
         chain_state = sha256_pkg::InitHash;
         fill_count  = 4'd0;
         digest_queue.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (digest_queue.size() == 0) begin
               report_mismatch("unexpected digest transfer", '0, rsp_bus.digest_word);
            end else begin
               head = digest_queue.pop_front();
               digest_count++;
               if (rsp_bus.digest_word !== head.digest)
                  report_mismatch("digest_word", head.digest, rsp_bus.digest_word);
               if (rsp_bus.word_position !== head.position)
                  report_mismatch("word_position", sha256_pkg::word_type'(head.position),
                                  sha256_pkg::word_type'(rsp_bus.word_position));
               if (rsp_bus.last_word !== head.last)
                  report_mismatch("last_word", sha256_pkg::word_type'(head.last),
                                  sha256_pkg::word_type'(rsp_bus.last_word));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            block_buf[fill_count] = req_bus.message_word;
            if (fill_count == 4'd15) begin
               fold_block_into_chain();
               // only the flag on the closing word of a block counts
               if (req_bus.final_block) begin
                  for (int i = 0; i < 8; i++)
                     digest_queue.push_back(
                        digest_entry_type'{chain_state[i], 3'(i), i == 7});
                  chain_state = sha256_pkg::InitHash;
               end
            end
            fill_count = fill_count + 4'd1;
         end
      end
      expected_left <= digest_queue.size();
   end

endmodule

[tb/sha256_block_hash_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 block hash testbench
// Feeds directed and random message blocks through the hash block under
// several idle and stall patterns, including a long output hold-off, and
// leaves prediction and comparison to the digest check beside it.
// ----------------------------------------------------------------------------
module sha256_block_hash_tb;

   logic clock;
   logic reset;
   logic hold_go;
   int   idle_pct;
   int   stall_pct;
   int   hold_cycles;
   int   words_sent;
   int   fail_count;
   int   expected_left;
   int   digest_count;

   sha256_req_if req_bus ();
   sha256_rsp_if rsp_bus ();

   sha256_block_hash u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sha256_digest_check u_digest_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .expected_left (expected_left),
      .digest_count  (digest_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // receiver: random stalls, or a counted hold-off when asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles   <= 0;
      end else if (hold_go) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles   <= 600;
      end else if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles   <= hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_word(input sha256_pkg::word_type w, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.message_word <= w;
      req_bus.final_block  <= fin;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   task automatic send_random_block(input logic fin);
      sha256_pkg::word_type w;
      int                   pick;
      for (int i = 0; i < 16; i++) begin
         pick = $urandom_range(7);
         w = (pick == 0) ? '0 : (pick == 1) ? '1 : sha256_pkg::word_type'($urandom);
         send_word(w, (i == 15) ? fin : 1'($urandom));
      end
   endtask

   // mostly single-block messages, some longer, now and then one left open
   task automatic send_messages(input int n_blocks);
      int left;
      int len;
      left = n_blocks;
      while (left > 0) begin
         len = ($urandom_range(9) < 7) ? 1 : $urandom_range(3, 2);
         if (len > left) len = left;
         for (int b = 0; b < len; b++)
            send_random_block((b == len - 1) && ($urandom_range(15) != 0));
         left -= len;
      end
   endtask

   task automatic drain_digests();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (expected_left == 0);
      @(posedge clock);
   endtask

   initial begin
      reset                = 1'b1;
      hold_go              = 1'b0;
      idle_pct             = 0;
      stall_pct            = 0;
      req_bus.valid        = 1'b0;
      req_bus.message_word = '0;
      req_bus.final_block  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // non-final block of extreme words, flag high on all but the closing word
      for (int i = 0; i < 16; i++)
         send_word((i % 3 == 0) ? 32'hffff_ffff : (i % 3 == 1) ? 32'h0000_0000 :
                   32'h8000_0001 ^ sha256_pkg::word_type'(i << 8), i != 15);
      // padded "abc", chained onto the block above
      for (int i = 0; i < 16; i++)
         send_word((i == 0) ? 32'h6162_6380 : (i == 15) ? 32'h0000_0018 : '0, i == 15);
      send_messages(3);

      idle_pct = 48;
      send_messages(2);

      idle_pct = 0;
      stall_pct <= 48;
      send_messages(2);

      idle_pct = 15;
      stall_pct <= 15;
      send_messages(2);

      // output held off while input keeps coming, until the block backs up
      drain_digests();
      idle_pct = 0;
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      for (int b = 0; b < 3; b++) send_random_block(1'b1);
      drain_digests();

      repeat (100) @(posedge clock);
      $display("covered %0d message words in directed, random and back-pressure phases",
               words_sent);
      $display("%0d digest words compared against the prediction", digest_count);
      if (fail_count == 0 && expected_left == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/sha256_pkg.sv
sv/sha256_if.sv
sv/sha256_ctrl.sv
sv/sha256_dp.sv
sv/sha256_block_hash.sv
tb/sha256_digest_check.sv
tb/sha256_block_hash_tb.sv
